### sv/bmirq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper package
// Types, function codes and decode addresses shared by the bank mapper blocks.
// ----------------------------------------------------------------------------
package bmirq_pkg;

    // Stream widths: input tdata carries addr, data, cycles padded to bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    // Output tdata carries irq_line, mirror_select, bank_number padded to bytes.
    localparam int M_TDATA_W = 16;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_QUERY_CPU = 2'd2,
        FUNC_QUERY_PPU = 2'd3
    } func_t;

    // Write addresses decoded by the mapper; all but the character base match exactly.
    localparam logic [15:0] ADDR_PRG0      = 16'h8000;
    localparam logic [15:0] ADDR_MIRROR    = 16'h9001;
    localparam logic [15:0] ADDR_IRQ_CTRL  = 16'h9003;
    localparam logic [15:0] ADDR_IRQ_LOAD  = 16'h9004;
    localparam logic [15:0] ADDR_LATCH_HI  = 16'h9005;
    localparam logic [15:0] ADDR_LATCH_LO  = 16'h9006;
    localparam logic [15:0] ADDR_PRG1      = 16'hA000;
    localparam logic [15:0] ADDR_CHR_BASE  = 16'hB000;
    localparam logic [15:0] ADDR_PRG2      = 16'hC000;

    // Query window limits.
    localparam logic [15:0] CPU_WIN_LOW    = 16'h8000;
    localparam logic [15:0] CPU_WIN_FIXED  = 16'hE000;
    localparam logic [15:0] PPU_WIN_TOP    = 16'h2000;

    // Counter constants.
    localparam logic signed [16:0] COUNT_TRIP    = -17'sd4;
    localparam logic signed [16:0] COUNT_RESTART = 17'sh0FFFF;

    // Bit that carries enables and the mirroring select in a write.
    localparam int CTRL_BIT = 7;

    // One input item.
    typedef struct packed {
        func_t       func;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [9:0]  cycles;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       irq_line;
        logic       mirror_select;
        logic [7:0] bank_number;
        logic       bank_valid;
    } result_t;

endpackage

### sv/bmirq_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper input stage
// Registers one incoming beat and unpacks it into an item.
// ----------------------------------------------------------------------------
module bmirq_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: addr[15:0], data[7:0], cycles[9:0], zero pad.
    input  logic [bmirq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0 up: func[1:0].
    input  logic [bmirq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                            advance,
    output logic                            item_valid,
    output bmirq_pkg::item_t                item
);

    logic             valid_reg;
    logic             valid_next;
    bmirq_pkg::item_t item_reg;
    logic             take;

    // The stage is free when empty or when its item moves on this cycle.
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.func   <= bmirq_pkg::func_t'(s_axis_tuser[1:0]);
            item_reg.addr   <= s_axis_tdata[15:0];
            item_reg.data   <= s_axis_tdata[23:16];
            item_reg.cycles <= s_axis_tdata[33:24];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/bmirq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper core
// Holds the bank, mirroring and interrupt counter state and forms results.
// ----------------------------------------------------------------------------
module bmirq_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  bmirq_pkg::item_t   item,
    output bmirq_pkg::result_t result
);

    logic [7:0]        prg_reg [3];
    logic [7:0]        prg_next [3];
    logic [7:0]        chr_reg [8];
    logic [7:0]        chr_next [8];
    logic              mirror_reg;
    logic              mirror_next;
    logic              irq_en_reg;
    logic              irq_en_next;
    logic              irq_pend_reg;
    logic              irq_pend_next;
    logic signed [16:0] count_reg;
    logic signed [16:0] count_next;
    logic [15:0]       reload_reg;
    logic [15:0]       reload_next;
    logic signed [16:0] count_diff;
    logic [7:0]        bank;
    logic              hit;

    // Counter after subtracting the elapsed cycles of a tick.
    assign count_diff = count_reg - $signed({7'd0, item.cycles});

    // Next state for writes and ticks.
    always_comb
    begin
        prg_next      = prg_reg;
        chr_next      = chr_reg;
        mirror_next   = mirror_reg;
        irq_en_next   = irq_en_reg;
        irq_pend_next = irq_pend_reg;
        count_next    = count_reg;
        reload_next   = reload_reg;
        case (item.func)
            bmirq_pkg::FUNC_WRITE:
            begin
                unique case (item.addr)
                    bmirq_pkg::ADDR_PRG0:     prg_next[0] = item.data;
                    bmirq_pkg::ADDR_PRG1:     prg_next[1] = item.data;
                    bmirq_pkg::ADDR_PRG2:     prg_next[2] = item.data;
                    bmirq_pkg::ADDR_MIRROR:   mirror_next = item.data[bmirq_pkg::CTRL_BIT];
                    bmirq_pkg::ADDR_IRQ_CTRL:
                    begin
                        irq_en_next   = item.data[bmirq_pkg::CTRL_BIT];
                        irq_pend_next = 1'b0;
                    end
                    bmirq_pkg::ADDR_IRQ_LOAD: count_next = $signed({1'b0, reload_reg});
                    bmirq_pkg::ADDR_LATCH_HI: reload_next[15:8] = item.data;
                    bmirq_pkg::ADDR_LATCH_LO: reload_next[7:0] = item.data;
                    default:
                    begin
                        // Character banks sit at eight consecutive addresses.
                        if (item.addr[15:3] == bmirq_pkg::ADDR_CHR_BASE[15:3])
                        begin
                            chr_next[item.addr[2:0]] = item.data;
                        end
                    end
                endcase
            end
            bmirq_pkg::FUNC_TICK:
            begin
                if (irq_en_reg)
                begin
                    if (count_diff < bmirq_pkg::COUNT_TRIP)
                    begin
                        irq_pend_next = 1'b1;
                        irq_en_next   = 1'b0;
                        count_next    = bmirq_pkg::COUNT_RESTART;
                    end
                    else
                    begin
                        count_next = count_diff;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Window lookup for queries; queries never change state.
    always_comb
    begin
        bank = 8'd0;
        hit  = 1'b0;
        case (item.func)
            bmirq_pkg::FUNC_QUERY_CPU:
            begin
                if (item.addr >= bmirq_pkg::CPU_WIN_LOW && item.addr < bmirq_pkg::CPU_WIN_FIXED)
                begin
                    bank = prg_reg[item.addr[14:13]];
                    hit  = 1'b1;
                end
            end
            bmirq_pkg::FUNC_QUERY_PPU:
            begin
                if (item.addr < bmirq_pkg::PPU_WIN_TOP)
                begin
                    bank = chr_reg[item.addr[12:10]];
                    hit  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The result shows the flags as they stand after this item.
    assign result.irq_line      = irq_pend_next;
    assign result.mirror_select = mirror_next;
    assign result.bank_number   = bank;
    assign result.bank_valid    = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_reg      <= '{default: 8'd0};
            chr_reg      <= '{default: 8'd0};
            mirror_reg   <= 1'b0;
            irq_en_reg   <= 1'b0;
            irq_pend_reg <= 1'b0;
            count_reg    <= 17'sd0;
            reload_reg   <= 16'd0;
        end
        else if (update)
        begin
            prg_reg      <= prg_next;
            chr_reg      <= chr_next;
            mirror_reg   <= mirror_next;
            irq_en_reg   <= irq_en_next;
            irq_pend_reg <= irq_pend_next;
            count_reg    <= count_next;
            reload_reg   <= reload_next;
        end
    end

endmodule

### sv/bmirq_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper output stage
// Result register that holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module bmirq_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  bmirq_pkg::result_t              result,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: irq_line, mirror_select, bank_number[7:0], zero pad.
    output logic [bmirq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: bank_valid.
    output logic                            m_axis_tuser
);

    logic               valid_reg;
    logic               valid_next;
    bmirq_pkg::result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // Pack the result beat.
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'd0, result_reg.bank_number, result_reg.mirror_select,
                            result_reg.irq_line};
    assign m_axis_tuser  = result_reg.bank_valid;

endmodule

### sv/bank_mapper_with_irq_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper with interrupt counter
// Cartridge bank mapper with bus write decode, window queries and a
// cycle-countdown interrupt.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel: tuser gives the kind (bus write, cycle
// tick, CPU window query, PPU window query) and tdata carries the address,
// the written byte and the elapsed cycle count. Every item gives exactly one
// beat on the m_axis channel with the interrupt line and mirroring bit as they
// stand after the item, and the bank and hit flag of a query.
// An accepted beat passes the input register and then the result register to
// become its result beat. The state update and the result are formed by one
// level of decode and a 17-bit subtract, so a new beat is taken every cycle
// while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more item; s_axis_tready drops only when both are full.
// Reset clears all bank registers, the mirroring bit, the interrupt enable,
// the pending flag, the counter and its reload latch, and empties both stages.
// ----------------------------------------------------------------------------
module bank_mapper_with_irq_counter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: addr[15:0], data[7:0], cycles[9:0], zero pad.
    input  logic [bmirq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0 up: func[1:0].
    input  logic [bmirq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: irq_line, mirror_select, bank_number[7:0], zero pad.
    output logic [bmirq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: bank_valid.
    output logic                            m_axis_tuser
);

    logic               item_valid;
    bmirq_pkg::item_t   item;
    bmirq_pkg::result_t result;
    logic               advance;

    // An item moves on when the result register is empty or being drained.
    assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

    bmirq_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    bmirq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .item   (item),
        .result (result)
    );

    bmirq_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### sv/bmirq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper port checker
// Watches the stream ports of the bank mapper and checks beat accounting.
// ----------------------------------------------------------------------------
module bmirq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bmirq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       s_beat;
    logic       m_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_axis_tvalid && m_axis_tready;

    // Beats taken in but not yet delivered.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_beat && !m_beat)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (m_beat && !s_beat)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result beat is never shown without an item behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 2'd0)
        else $error("result beat without an accepted item");

    // The two stages hold at most two items.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two items in flight");

    // Input back-pressure only when the result register is occupied and both stages are full.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && inflight_reg == 2'd2)
        else $error("input stalled while the block is not full");

    // A miss always reports bank zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[9:2] == 8'd0)
        else $error("bank number set on a miss");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind bank_mapper_with_irq_counter_unit bmirq_checker u_bmirq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
